### rtl/core/ftmrs_pkg.sv
// shared types and constants for the fenwick tree modular range sum unit
// used by ftmrs_ctrl, ftmrs_dpath and the top level
package ftmrs_pkg;

   localparam int unsigned IDX_W  = 13;  // 1-based element index and size
   localparam int unsigned NODE_W = 14;  // walk index, holds up to twice the size
   localparam int unsigned VAL_W  = 30;  // residue width

   localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;

   typedef enum logic [1:0] {
      CMD_QUERY = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_SUB   = 2'd2,
      CMD_NONE  = 2'd3
   } ftmrs_op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_QH_READ,
      ST_QH_ACC,
      ST_QL_READ,
      ST_QL_ACC,
      ST_U_READ,
      ST_U_WRITE,
      ST_DONE
   } ftmrs_state_type;

   typedef struct packed {
      logic load_req;    // capture the request word
      logic clear_wr;    // write zero at the sweep address and advance it
      logic start_hi;    // begin prefix walk at last_index
      logic start_lo;    // keep high prefix, begin walk at first_index-1
      logic start_upd;   // begin update at first_index
      logic rd_node;     // read node n
      logic acc_node;    // fold node into accumulator, step down
      logic wr_node;     // write updated node, step up
      logic next_pos;    // move to next element of the range
      logic set_result;  // load the response register
   } ftmrs_cmd_type;

   typedef struct packed {
      logic clear_last;  // sweep is at the last entry
      logic bad;         // range rejected
      logic is_query;
      logic is_skip;     // unused command code
      logic n_zero;      // downward walk finished
      logic up_last;     // upward walk leaves the active size
      logic range_done;  // current element is last_index
      logic rsp_free;    // response register can take a word
   } ftmrs_status_type;

endpackage

### rtl/core/ftmrs_ctrl.sv
// controller state machine of the fenwick tree range sum unit
// depends on ftmrs_pkg; drives ftmrs_dpath through command and status structs
module ftmrs_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  ftmrs_pkg::ftmrs_status_type status,
   output ftmrs_pkg::ftmrs_cmd_type    cmd
);
   import ftmrs_pkg::*;

   ftmrs_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.is_skip) begin
               state_in = ST_IDLE;
            end else if (status.bad) begin
               state_in = ST_DONE;
            end else if (status.is_query) begin
               state_in = ST_QH_READ;
            end else begin
               state_in = ST_U_READ;
            end
         end
         ST_QH_READ: begin
            state_in = status.n_zero ? ST_QL_READ : ST_QH_ACC;
         end
         ST_QH_ACC: begin
            state_in = ST_QH_READ;
         end
         ST_QL_READ: begin
            state_in = status.n_zero ? ST_DONE : ST_QL_ACC;
         end
         ST_QL_ACC: begin
            state_in = ST_QL_READ;
         end
         ST_U_READ: begin
            state_in = ST_U_WRITE;
         end
         ST_U_WRITE: begin
            if (status.up_last && status.range_done) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_U_READ;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_CHECK: begin
            cmd.start_hi  = !status.bad && status.is_query && !status.is_skip;
            cmd.start_upd = !status.bad && !status.is_query && !status.is_skip;
         end
         ST_QH_READ: begin
            cmd.rd_node  = !status.n_zero;
            cmd.start_lo = status.n_zero;
         end
         ST_QL_READ: begin
            cmd.rd_node = !status.n_zero;
         end
         ST_QH_ACC, ST_QL_ACC: begin
            cmd.acc_node = 1'b1;
         end
         ST_U_READ: begin
            cmd.rd_node = 1'b1;
         end
         ST_U_WRITE: begin
            cmd.wr_node  = 1'b1;
            // walk left the active size: go on with the next element
            cmd.next_pos = status.up_last && !status.range_done;
         end
         ST_DONE: begin
            cmd.set_result = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/core/ftmrs_dpath.sv
// datapath of the fenwick tree range sum unit: node memory, walk index,
// modular adders, product sequence generator, size register, response register
// depends on ftmrs_pkg
module ftmrs_dpath #(
   parameter int unsigned DEPTH = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [31:0]                 req_tdata,
   input  logic                        csr_wr_en,
   input  logic [ftmrs_pkg::IDX_W-1:0] csr_wr_data,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output logic [31:0]                 rsp_tdata,
   output logic                        rsp_tuser,
   input  ftmrs_pkg::ftmrs_cmd_type    cmd,
   output ftmrs_pkg::ftmrs_status_type status
);
   import ftmrs_pkg::*;

   localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned SIZE_CAP = (DEPTH < 8191) ? DEPTH : 8191;

   logic [VAL_W-1:0]  mem [DEPTH];

   logic [IDX_W-1:0]  size_ff;
   logic [AW-1:0]     clr_ff;
   logic              rsp_valid_ff;
   logic [VAL_W-1:0]  rsp_sum_ff;
   logic              rsp_err_ff;

   logic [1:0]        op_ff;
   logic [IDX_W-1:0]  first_ff, last_ff, pos_ff;
   logic [NODE_W-1:0] n_ff;
   logic [VAL_W-1:0]  acc_ff, hi_ff, rd_ff;
   logic [VAL_W-1:0]  r_ff;       // f(k) mod prime, f(k) = (k+1)(k+2)(k+3)
   logic [27:0]       d_ff;       // f(k+1) - f(k), exact
   logic [15:0]       e_ff;       // d(k+1) - d(k) = 6(k+3)

   logic [IDX_W-1:0]  eff_size;
   logic [NODE_W-1:0] low_bit, n_down, n_up;
   logic [AW-1:0]     node_addr, wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic              mem_we;
   logic [VAL_W:0]    acc_sum, add_sum, sub_tmp, diff_tmp, r_sum;
   logic [VAL_W-1:0]  acc_next, add_res, sub_res, r_next;

   assign eff_size = (size_ff > IDX_W'(SIZE_CAP)) ? IDX_W'(SIZE_CAP) : size_ff;

   assign low_bit   = n_ff & (~n_ff + 14'd1);
   assign n_down    = n_ff & (n_ff - 14'd1);
   assign n_up      = n_ff + low_bit;
   assign node_addr = AW'(n_ff - 14'd1);

   assign acc_sum  = {1'b0, acc_ff} + {1'b0, rd_ff};
   assign acc_next = (acc_sum >= {1'b0, PRIME}) ? VAL_W'(acc_sum - {1'b0, PRIME})
                                                 : acc_sum[VAL_W-1:0];
   assign add_sum  = {1'b0, rd_ff} + {1'b0, r_ff};
   assign add_res  = (add_sum >= {1'b0, PRIME}) ? VAL_W'(add_sum - {1'b0, PRIME})
                                                 : add_sum[VAL_W-1:0];
   assign sub_tmp  = {1'b0, rd_ff} + ((rd_ff < r_ff) ? {1'b0, PRIME} : '0) - {1'b0, r_ff};
   assign sub_res  = sub_tmp[VAL_W-1:0];
   assign diff_tmp = {1'b0, hi_ff} + ((hi_ff < acc_ff) ? {1'b0, PRIME} : '0)
                     - {1'b0, acc_ff};
   assign r_sum    = {1'b0, r_ff} + (VAL_W+1)'(d_ff);
   assign r_next   = (r_sum >= {1'b0, PRIME}) ? VAL_W'(r_sum - {1'b0, PRIME})
                                               : r_sum[VAL_W-1:0];

   assign mem_we  = cmd.clear_wr || cmd.wr_node;
   assign wr_addr = cmd.clear_wr ? clr_ff : node_addr;
   assign wr_data = cmd.clear_wr ? '0 : ((op_ff == CMD_SUB) ? sub_res : add_res);

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      if (cmd.rd_node) rd_ff <= mem[node_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= 13'd4096;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) size_ff <= csr_wr_data;
         if (cmd.clear_wr) clr_ff <= clr_ff + AW'(1);
         if (cmd.set_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_tdata[1:0];
         first_ff <= req_tdata[14:2];
         last_ff  <= req_tdata[27:15];
      end
      if (cmd.start_hi) begin
         n_ff   <= {1'b0, last_ff};
         acc_ff <= '0;
      end
      if (cmd.start_lo) begin
         hi_ff  <= acc_ff;
         n_ff   <= {1'b0, first_ff - 13'd1};
         acc_ff <= '0;
      end
      if (cmd.acc_node) begin
         acc_ff <= acc_next;
         n_ff   <= n_down;
      end
      if (cmd.start_upd) begin
         pos_ff <= first_ff;
         n_ff   <= {1'b0, first_ff};
         r_ff   <= 30'd6;
         d_ff   <= 28'd18;
         e_ff   <= 16'd18;
      end
      if (cmd.wr_node && !cmd.next_pos) n_ff <= n_up;
      // next element restarts the upward walk at pos+1
      if (cmd.next_pos) begin
         pos_ff <= pos_ff + 13'd1;
         n_ff   <= {1'b0, pos_ff + 13'd1};
         r_ff   <= r_next;
         d_ff   <= d_ff + 28'(e_ff);
         e_ff   <= e_ff + 16'd6;
      end
      if (cmd.set_result) begin
         rsp_err_ff <= status.bad;
         rsp_sum_ff <= (status.bad || !status.is_query) ? '0 : diff_tmp[VAL_W-1:0];
      end
   end

   assign status.clear_last = (clr_ff == AW'(DEPTH - 1));
   assign status.bad        = (first_ff == '0) || (first_ff > last_ff) || (last_ff > eff_size);
   assign status.is_query   = (op_ff == CMD_QUERY);
   assign status.is_skip    = (op_ff == CMD_NONE);
   assign status.n_zero     = (n_ff == '0);
   assign status.up_last    = (n_up > {1'b0, eff_size});
   assign status.range_done = (pos_ff == last_ff);
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_sum_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

### rtl/core/fenwick_tree_modular_range_sum_unit.sv
// a query folds each node of its downward walks from last_index and first_index-1;
// an update reads and writes each node on the upward walk of every element in the
// range; a rejected range goes straight to the response.
// one word at a time: the next is taken only after the result is loaded; an unused
// command gives no response; a stalled response holds the unit.
// reset: synchronous; a pass then zeroes all DEPTH nodes; active_size is 4096
module fenwick_tree_modular_range_sum_unit #(
   parameter int unsigned DEPTH = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,    // cmd, first_index, last_index
   input  logic                        csr_wr_en,
   input  logic [ftmrs_pkg::IDX_W-1:0] csr_wr_data,  // active_size
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,    // range_sum
   output logic                        rsp_tuser     // range_error
);
   import ftmrs_pkg::*;

   ftmrs_cmd_type    cmd;
   ftmrs_status_type status;

   ftmrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ftmrs_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

### verif/fenwick_tree_modular_range_sum_unit_test.sv
// self-checking bench for fenwick_tree_modular_range_sum_unit: a scoreboard
// class mirrors the node array and the size register and predicts every word
// depends on ftmrs_pkg and the unit itself
module fenwick_tree_modular_range_sum_unit_test;
   import ftmrs_pkg::*;

   localparam int unsigned TREE_DEPTH = 4096;
   localparam int unsigned MAX_INDEX  = (1 << IDX_W) - 1;
   localparam longint unsigned MOD    = longint'(PRIME);

   typedef struct packed {
      logic [VAL_W-1:0] sum;
      logic             err;
   } sum_result_type;

   class range_sum_scoreboard;
      bit [VAL_W-1:0] nodes [TREE_DEPTH];
      bit [IDX_W-1:0] size_reg;
      sum_result_type pending_sums [$];
      int unsigned    mismatches;
      int unsigned    n_query;
      int unsigned    n_update;
      int unsigned    n_rejected;
      int unsigned    n_checked;

      function new();
         foreach (nodes[i]) nodes[i] = '0;
         size_reg = IDX_W'(4096);
      endfunction

      function int unsigned eff_size();
         return (size_reg < TREE_DEPTH) ? size_reg : TREE_DEPTH;
      endfunction

      function void set_size(bit [IDX_W-1:0] value);
         size_reg = value;
      endfunction

      function int outstanding();
         return pending_sums.size();
      endfunction

      function longint unsigned prefix_residue(int unsigned n);
         longint unsigned acc;
         acc = 0;
         while (n > 0) begin
            acc = (acc + nodes[n-1]) % MOD;
            n = n - (n & (~n + 1));
         end
         return acc;
      endfunction

      function void add_to_element(int unsigned pos, longint unsigned amount,
                                   int unsigned bound);
         int unsigned n;
         n = pos;
         while (n >= 1 && n <= bound) begin
            nodes[n-1] = VAL_W'((nodes[n-1] + amount) % MOD);
            n = n + (n & (~n + 1));
         end
      endfunction

      function void note_request(ftmrs_op_type op, bit [IDX_W-1:0] first,
                                 bit [IDX_W-1:0] last);
         int unsigned     bound;
         longint unsigned hi, lo, k, v;
         sum_result_type  res;
         if (op == CMD_NONE) return;
         bound = eff_size();
         res.sum = '0;
         res.err = (first == 0) || (first > last) || (last > bound);
         if (res.err) begin
            n_rejected++;
         end else if (op == CMD_QUERY) begin
            n_query++;
            hi = prefix_residue(last);
            lo = prefix_residue(first - 1);
            res.sum = VAL_W'((hi + MOD - lo) % MOD);
         end else begin
            n_update++;
            for (int unsigned pos = first; pos <= last; pos++) begin
               k = pos - first;
               v = ((k + 1) * (k + 2) % MOD) * (k + 3) % MOD;
               if (op == CMD_SUB) v = (MOD - v) % MOD;
               add_to_element(pos, v, bound);
            end
         end
         pending_sums.push_back(res);
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_result(logic [31:0] data, logic user);
         sum_result_type want;
         if (pending_sums.size() == 0) begin
            report($sformatf("unexpected word sum=%0d err=%0b", data[VAL_W-1:0], user));
            return;
         end
         want = pending_sums.pop_front();
         n_checked++;
         if (data[VAL_W-1:0] !== want.sum)
            report($sformatf("range_sum got %0d want %0d", data[VAL_W-1:0], want.sum));
         if (user !== want.err)
            report($sformatf("range_error got %0b want %0b", user, want.err));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [31:0]          req_tdata;    // cmd, first_index, last_index
   logic                 csr_wr_en;
   logic [IDX_W-1:0]     csr_wr_data;  // active_size
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [31:0]          rsp_tdata;    // range_sum
   logic                 rsp_tuser;    // range_error

   range_sum_scoreboard sb = new();
   bit                  quiet = 1'b0;
   int unsigned         n_sizes = 1;

   fenwick_tree_modular_range_sum_unit #(.DEPTH(TREE_DEPTH)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // receiver stalls in random bursts while quiet is clear
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task send_word(ftmrs_op_type op, bit [IDX_W-1:0] first, bit [IDX_W-1:0] last);
      @(negedge clock);
      req_tdata  <= {4'b0, last, first, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, first, last);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5) - 1) @(negedge clock);
      end
   endtask

   // drop valid, let every outstanding word come back, then allow for a
   // possible trailing unused-command word still in the pipe
   task settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task write_size(bit [IDX_W-1:0] value);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_size(value);
      n_sizes++;
   endtask

   task random_word(output bit counted);
      int unsigned  bound, f, l, span, pick;
      ftmrs_op_type op;
      bound   = sb.eff_size();
      pick    = $urandom_range(0, 99);
      counted = 1'b1;
      if (pick < 5) begin
         send_word(CMD_NONE, IDX_W'($urandom), IDX_W'($urandom));
         counted = 1'b0;
         return;
      end
      if (pick < 15 || bound == 0) begin
         op = ftmrs_op_type'($urandom_range(0, 2));
         case ($urandom_range(0, 3))
            0: begin
               f = 0;
               l = $urandom_range(0, MAX_INDEX);
            end
            1: begin
               f = $urandom_range(2, MAX_INDEX);
               l = $urandom_range(1, f - 1);
            end
            2: begin
               l = $urandom_range(bound + 1, MAX_INDEX);
               f = $urandom_range(1, l);
            end
            default: begin
               f = $urandom_range(0, MAX_INDEX);
               l = $urandom_range(0, MAX_INDEX);
            end
         endcase
      end else begin
         f    = $urandom_range(1, bound);
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            op = CMD_QUERY;
            if ($urandom_range(0, 1)) l = $urandom_range(f, bound);
            else l = f + $urandom_range(0, 7);
         end else begin
            op = (pick < 75) ? CMD_ADD : CMD_SUB;
            // updates cost a tree walk per element, so keep most ranges short
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            l = f + span - 1;
         end
         if (l > bound) l = bound;
      end
      send_word(op, IDX_W'(f), IDX_W'(l));
   endtask

   task run_phase(int unsigned count);
      int unsigned done;
      bit          counted;
      done = 0;
      while (done < count) begin
         random_word(counted);
         if (counted) done++;
      end
   endtask

   initial begin
      #8_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int unsigned sizes [12];
      sizes       = '{4096, 1, 2, 3, 16, 4096, 0, 100, 8191, 777, 4095, 4096};
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset size
      send_word(CMD_QUERY, 1, 4096);
      send_word(CMD_ADD, 1, 1);
      send_word(CMD_QUERY, 1, 1);
      send_word(CMD_ADD, 4096, 4096);
      send_word(CMD_QUERY, 4096, 4096);
      send_word(CMD_ADD, 1, 4096);
      send_word(CMD_QUERY, 1, 4096);
      send_word(CMD_QUERY, 2, 4095);
      send_word(CMD_SUB, 1, 4096);
      send_word(CMD_SUB, 4096, 4096);
      send_word(CMD_QUERY, 4096, 4096);
      send_word(CMD_SUB, 10, 12);
      send_word(CMD_QUERY, 1, 20);
      send_word(CMD_QUERY, 11, 11);
      send_word(CMD_ADD, 0, 5);
      send_word(CMD_QUERY, 5, 4);
      send_word(CMD_SUB, 1, 4097);
      send_word(CMD_QUERY, 8191, 8191);
      send_word(CMD_QUERY, 1, 8191);
      send_word(CMD_NONE, 0, 0);
      send_word(CMD_NONE, 8191, 8191);
      send_word(CMD_ADD, 2730, 2740);
      send_word(CMD_QUERY, 2730, 3413);
      send_word(CMD_QUERY, 2735, 2745);

      // resizing keeps node contents, so later phases see earlier updates
      foreach (sizes[i]) begin
         write_size(IDX_W'(sizes[i]));
         if (i == 11) quiet = 1'b1;
         run_phase(sizes[i] == 0 ? 30 : 145);
      end

      settle();
      repeat (40) @(posedge clock);
      if (sb.outstanding() != 0) sb.report("expected words never arrived");
      $display("covered %0d queries, %0d updates and %0d rejected ranges",
               sb.n_query, sb.n_update, sb.n_rejected);
      $display("over %0d size settings, %0d words checked", n_sizes, sb.n_checked);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/ftmrs_pkg.sv
rtl/core/ftmrs_ctrl.sv
rtl/core/ftmrs_dpath.sv
rtl/core/fenwick_tree_modular_range_sum_unit.sv
verif/fenwick_tree_modular_range_sum_unit_test.sv
